@@ design/rsli_pkg.sv @@
// Shared constants and types for the RGB strip LUT grading block.
package rsli_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = 8;
	localparam int ENTRY_W     = 8;
	localparam int PIX_W       = 18;
	localparam int OUT_W       = 17;

	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic en;
		logic rd;
		logic wr;
	} lane_ctrl_t;

endpackage

@@ design/rsli_lane.sv @@
// One colour lane: table memory, index split, blend and divide by 255.
module rsli_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  rsli_pkg::lane_ctrl_t             ctrl,
	input  logic [rsli_pkg::IDX_W-1:0]       wr_index,
	input  logic [rsli_pkg::ENTRY_W-1:0]     wr_data,
	input  logic signed [rsli_pkg::PIX_W-1:0] pixel,
	output logic [rsli_pkg::OUT_W-1:0]       result
);
	import rsli_pkg::*;

	localparam int CW     = (FRAC_BITS + 2 > PIX_W) ? FRAC_BITS + 2 : PIX_W;
	localparam int UW     = FRAC_BITS + 1;
	localparam int TW     = FRAC_BITS + 9;
	localparam int XW     = FRAC_BITS + 8;
	localparam int PW     = FRAC_BITS + 9;
	localparam int NUM_W  = FRAC_BITS + 8;
	localparam int RW     = FRAC_BITS + 9;
	localparam int DIV_SH = FRAC_BITS + 16;
	localparam int PRW    = NUM_W + RW;
	localparam int QW     = FRAC_BITS + 1;
	localparam longint unsigned ONE   = 64'd1 << FRAC_BITS;
	localparam longint unsigned HALF  = 64'd1 << (FRAC_BITS - 1);
	localparam longint unsigned MAXX  = 64'd255 << FRAC_BITS;
	localparam longint unsigned RECIP = (64'd1 << DIV_SH) / 64'd255;

	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

	logic signed [CW-1:0] pxe;
	logic [UW-1:0]        u;
	logic [TW-1:0]        t;
	logic [TW-1:0]        d;
	logic [XW-1:0]        x;
	logic [IDX_W-1:0]     i0;
	logic [IDX_W-1:0]     i1;
	logic [FRAC_BITS-1:0] f;

	logic [ENTRY_W-1:0]   t0_s1, t1_s1;
	logic [FRAC_BITS-1:0] f_s1;
	logic [PW-1:0]        p0_s2, p1_s2;
	logic [NUM_W-1:0]     nr_s3;
	logic [PRW-1:0]       prod_s4;
	logic [NUM_W-1:0]     nr_s4;
	logic [OUT_W-1:0]     res_s5;

	logic [UW-1:0]        w;
	logic [QW-1:0]        q_est;
	logic [NUM_W-1:0]     q255;
	logic [NUM_W-1:0]     rem;
	logic [QW-1:0]        q;

	always_comb begin
		pxe = CW'(pixel);
		if (pxe[CW-1]) begin
			u = '0;
		end else if ($unsigned(pxe) > CW'(ONE)) begin
			u = UW'(ONE);
		end else begin
			u = UW'($unsigned(pxe));
		end
		t = {u, 8'b0};
		d = t - TW'(HALF);
		if (t < TW'(HALF)) begin
			x = '0;
		end else if (d > TW'(MAXX)) begin
			x = XW'(MAXX);
		end else begin
			x = XW'(d);
		end
		i0 = x[XW-1:FRAC_BITS];
		f  = x[FRAC_BITS-1:0];
		i1 = (i0 == IDX_MAX) ? i0 : i0 + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem[wr_index] <= wr_data;
		end
		if (ctrl.rd) begin
			t0_s1 <= mem[i0];
			t1_s1 <= mem[i1];
			f_s1  <= f;
		end
	end

	assign w = UW'(ONE) - UW'(f_s1);

	always_comb begin
		q_est = prod_s4[PRW-1:DIV_SH];
		q255  = NUM_W'({q_est, 8'b0}) - NUM_W'(q_est);
		rem   = nr_s4 - q255;
		q     = (rem >= NUM_W'(255)) ? q_est + 1'b1 : q_est;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			p0_s2   <= PW'(t0_s1) * PW'(w);
			p1_s2   <= PW'(t1_s1) * PW'(f_s1);
			nr_s3   <= NUM_W'(p0_s2 + p1_s2 + PW'(127));
			prod_s4 <= PRW'(nr_s3) * PRW'(RW'(RECIP));
			nr_s4   <= nr_s3;
			res_s5  <= OUT_W'(q);
		end
	end

	assign result = res_s5;

endmodule

@@ design/rsli_merge.sv @@
// Merge of the three lane results into one output beat, with skid buffer.
module rsli_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	input  logic [rsli_pkg::OUT_W-1:0] lane_red,
	input  logic [rsli_pkg::OUT_W-1:0] lane_green,
	input  logic [rsli_pkg::OUT_W-1:0] lane_blue,
	output logic                       take,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rsli_pkg::OUT_W-1:0] out_red,
	output logic [rsli_pkg::OUT_W-1:0] out_green,
	output logic [rsli_pkg::OUT_W-1:0] out_blue
);
	import rsli_pkg::*;

	logic             out_v_q, skid_v_q;
	logic [OUT_W-1:0] out_r_q, out_g_q, out_b_q;
	logic [OUT_W-1:0] skid_r_q, skid_g_q, skid_b_q;

	assign take = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			out_v_q  <= skid_v_q || up_valid;
			skid_v_q <= 1'b0;
		end else if (up_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_r_q <= skid_r_q;
				out_g_q <= skid_g_q;
				out_b_q <= skid_b_q;
			end else begin
				out_r_q <= lane_red;
				out_g_q <= lane_green;
				out_b_q <= lane_blue;
			end
		end else if (!skid_v_q) begin
			skid_r_q <= lane_red;
			skid_g_q <= lane_green;
			skid_b_q <= lane_blue;
		end
	end

	assign out_valid = out_v_q;
	assign out_red   = out_r_q;
	assign out_green = out_g_q;
	assign out_blue  = out_b_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid full with empty output");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ready && up_valid))
		else $error("skid filled without stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_ready) |=> (out_v_q && !skid_v_q))
		else $error("skid beat lost on drain");

endmodule

@@ design/rgb_strip_lut_interpolate_top.sv @@
// A pixel beat passes lane stages s1 to s5 and the merge output register to out_valid.
// Throughput: one beat per clock while in_ready, load or pixel; loads write all three tables, no result.
// Each lane holds its table in a memory read at two addresses on the accepting edge.
// Back-pressure stalls the whole lane pipeline once the output skid stage is full.
// Reset clears the stage valids and the output/skid valids; table contents are not reset.
module rgb_strip_lut_interpolate_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [rsli_pkg::IDX_W-1:0]         entry_index,
	input  logic [rsli_pkg::ENTRY_W-1:0]       entry_red,
	input  logic [rsli_pkg::ENTRY_W-1:0]       entry_green,
	input  logic [rsli_pkg::ENTRY_W-1:0]       entry_blue,
	input  logic signed [rsli_pkg::PIX_W-1:0]  pixel_red,
	input  logic signed [rsli_pkg::PIX_W-1:0]  pixel_green,
	input  logic signed [rsli_pkg::PIX_W-1:0]  pixel_blue,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rsli_pkg::OUT_W-1:0]         out_red,
	output logic [rsli_pkg::OUT_W-1:0]         out_green,
	output logic [rsli_pkg::OUT_W-1:0]         out_blue
);
	import rsli_pkg::*;

	logic       en;
	logic       accept;
	lane_ctrl_t ctrl;
	logic       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [OUT_W-1:0] res_r, res_g, res_b;

	assign in_ready = en;
	assign accept   = in_valid && en;
	assign ctrl.en  = en;
	assign ctrl.rd  = accept && (req_type == REQ_PIXEL);
	assign ctrl.wr  = accept && (req_type == REQ_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= ctrl.rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	rsli_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
		.clk(clk), .ctrl(ctrl), .wr_index(entry_index), .wr_data(entry_red),
		.pixel(pixel_red), .result(res_r)
	);

	rsli_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
		.clk(clk), .ctrl(ctrl), .wr_index(entry_index), .wr_data(entry_green),
		.pixel(pixel_green), .result(res_g)
	);

	rsli_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
		.clk(clk), .ctrl(ctrl), .wr_index(entry_index), .wr_data(entry_blue),
		.pixel(pixel_blue), .result(res_b)
	);

	rsli_merge u_merge (
		.clk(clk), .arst_n(arst_n), .up_valid(v_s5),
		.lane_red(res_r), .lane_green(res_g), .lane_blue(res_b),
		.take(en), .out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue)
	);

endmodule
